/* rtl/core/core_fit_fcfs_dispatcher_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the core dispatcher
// Concurrent check wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CORE_FIT_FCFS_DISPATCHER_CORE_DEFINES_SVH
`define CORE_FIT_FCFS_DISPATCHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define CFFD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cffd: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define CFFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cffd: next-cycle check failed");
`else
`define CFFD_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define CFFD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/cffd_pkg.sv */
// ----------------------------------------------------------------------------
// Core dispatcher package
// Field widths, event codes and shared types of the core dispatcher.
// ----------------------------------------------------------------------------
package cffd_pkg;

   // Default depth of the job table.
   localparam int unsigned TABLE_DEPTH = 16;

   // Results produced by one request never exceed this count.
   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned RES_W       = $clog2(MAX_RESULTS + 1);

   // Payload field widths.
   localparam int unsigned TAG_W   = 8;
   localparam int unsigned CORES_W = 7;
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned MAX_CORES = (1 << CORES_W) - 1;

   // Configuration port.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_TOTAL_CORES = '0;

   // Operation codes.
   localparam logic OP_SUBMIT = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   // Result event codes.
   localparam logic [KIND_W-1:0] EV_QUEUED     = 3'd0;
   localparam logic [KIND_W-1:0] EV_DISPATCHED = 3'd1;
   localparam logic [KIND_W-1:0] EV_RELEASED   = 3'd2;
   localparam logic [KIND_W-1:0] EV_TABLE_FULL = 3'd3;
   localparam logic [KIND_W-1:0] EV_TOO_MANY   = 3'd4;
   localparam logic [KIND_W-1:0] EV_UNKNOWN    = 3'd5;

   // One job held in a table cell.
   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [CORES_W-1:0] cores;
      logic               running;
   } entry_type;

   // Controls shared by the whole row of cells.
   typedef struct packed {
      logic shift;
      logic load;
   } chain_ctl_type;

   // Controls seen by a single cell.
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

   // Configuration write towards the sequencer.
   typedef struct packed {
      logic               write;
      logic [CORES_W-1:0] total;
   } cfg_write_type;

endpackage

/* rtl/core/cffd_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying job submit and finish requests.
// ----------------------------------------------------------------------------
interface cffd_req_if;

   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [cffd_pkg::TAG_W-1:0]   job_tag;
   logic [cffd_pkg::CORES_W-1:0] cores_needed;

   modport source (output valid, output operation, output job_tag,
                   output cores_needed, input ready);
   modport sink   (input valid, input operation, input job_tag,
                   input cores_needed, output ready);

endinterface

/* rtl/core/cffd_rsp_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the results of each request.
// ----------------------------------------------------------------------------
interface cffd_rsp_if;

   logic                        valid;
   logic                        ready;
   logic [cffd_pkg::TAG_W-1:0]  job_tag_res;
   logic [cffd_pkg::KIND_W-1:0] event_kind;
   logic                        last;

   modport source (output valid, output job_tag_res, output event_kind,
                   output last, input ready);
   modport sink   (input valid, input job_tag_res, input event_kind,
                   input last, output ready);

endinterface

/* rtl/core/cffd_cell.sv */
// ----------------------------------------------------------------------------
// Job table cell
// One entry of the job table; takes its upper neighbour on a shift or a
// fresh entry on a load.
// ----------------------------------------------------------------------------
module cffd_cell (
   input  logic                    clock,
   input  cffd_pkg::cell_ctl_type  ctl,
   input  cffd_pkg::entry_type     nbr_entry,
   input  cffd_pkg::entry_type     wr_entry,
   output cffd_pkg::entry_type     entry
);

   cffd_pkg::entry_type entry_ff;
   cffd_pkg::entry_type entry_in;

   // A load wins over the shift: it refills the slot at the tail of the row.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.load) begin
         entry_in = wr_entry;
      end else if (ctl.shift) begin
         entry_in = nbr_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* rtl/core/cffd_ctrl.sv */
// ----------------------------------------------------------------------------
// Dispatcher sequencer
// Walks the row of cells one entry per cycle while no fitting job waits for the
// result register, keeps the core accounting and drives the result register.
// ----------------------------------------------------------------------------
module cffd_ctrl #(
   parameter int unsigned TABLE_DEPTH = cffd_pkg::TABLE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   cffd_req_if.sink                      req_chan,
   cffd_rsp_if.source                    rsp_chan,
   input  cffd_pkg::cfg_write_type       cfg_wr,
   output logic [cffd_pkg::CORES_W-1:0]  total_cores,
   input  cffd_pkg::entry_type           head_entry,
   output cffd_pkg::chain_ctl_type       chain_ctl,
   output logic [$clog2(TABLE_DEPTH)-1:0] wr_pos,
   output cffd_pkg::entry_type           wr_entry
);

   localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
   localparam int unsigned BUSY_W = $clog2(TABLE_DEPTH * cffd_pkg::MAX_CORES + 1);
   localparam int unsigned CW     = cffd_pkg::CORES_W;
   localparam int unsigned RW     = cffd_pkg::RES_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
   localparam logic [RW-1:0]    RES_CAP   = RW'(cffd_pkg::MAX_RESULTS);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FIND = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              len_ff, len_in;
   logic [CNT_W-1:0]              steps_ff, steps_in;
   logic [CW-1:0]                 free_ff, free_in;
   logic [CW-1:0]                 total_ff, total_in;
   logic [BUSY_W-1:0]             busy_ff, busy_in;
   logic                          found_ff, found_in;
   logic [RW-1:0]                 results_ff, results_in;
   logic [cffd_pkg::TAG_W-1:0]    tag_ff, tag_in;
   logic [cffd_pkg::TAG_W-1:0]    pend_tag_ff, pend_tag_in;
   logic [cffd_pkg::KIND_W-1:0]   pend_kind_ff, pend_kind_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cffd_pkg::TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;
   logic [cffd_pkg::KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic              slot_free;
   logic              head_match;
   logic              head_fit;
   logic [CW:0]       release_sum;
   logic [CNT_W-1:0]  len_m1;
   logic [BUSY_W-1:0] total_ext;
   logic [CW-1:0]     free_cfg;

   // The result register can take a new result when empty or being drained.
   assign slot_free   = !rsp_valid_ff || rsp_chan.ready;
   assign head_match  = !found_ff && head_entry.running && (head_entry.tag == tag_ff);
   assign head_fit    = !head_entry.running && (head_entry.cores <= free_ff)
                        && (results_ff < RES_CAP);
   assign release_sum = {1'b0, free_ff} + {1'b0, head_entry.cores};
   assign len_m1      = len_ff - CNT_W'(1);

   // Free cores after a new core total: total less the running load, floored at zero.
   assign total_ext = BUSY_W'(cfg_wr.total);
   assign free_cfg  = (busy_ff >= total_ext) ? '0 : CW'(total_ext - busy_ff);

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      steps_in     = steps_ff;
      free_in      = free_ff;
      total_in     = total_ff;
      busy_in      = busy_ff;
      found_in     = found_ff;
      results_in   = results_ff;
      tag_in       = tag_ff;
      pend_tag_in  = pend_tag_ff;
      pend_kind_in = pend_kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_tag_in   = rsp_tag_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      chain_ctl    = '0;
      wr_pos       = len_m1[IDX_W-1:0];
      wr_entry     = head_entry;

      case (state_ff)
         // Take a request; a submit is appended at once unless refused, a finish needs a search.
         ST_IDLE: begin
            if (req_chan.valid) begin
               pend_tag_in = req_chan.job_tag;
               results_in  = RW'(1);
               if (req_chan.operation == cffd_pkg::OP_SUBMIT) begin
                  state_in = ST_SCAN;
                  steps_in = len_ff;
                  if (req_chan.cores_needed > total_ff) begin
                     pend_kind_in = cffd_pkg::EV_TOO_MANY;
                  end else if (len_ff == DEPTH_CNT) begin
                     pend_kind_in = cffd_pkg::EV_TABLE_FULL;
                  end else begin
                     chain_ctl.load = 1'b1;
                     wr_pos         = len_ff[IDX_W-1:0];
                     wr_entry.tag     = req_chan.job_tag;
                     wr_entry.cores   = req_chan.cores_needed;
                     wr_entry.running = 1'b0;
                     len_in       = len_ff + CNT_W'(1);
                     steps_in     = len_ff + CNT_W'(1);
                     pend_kind_in = cffd_pkg::EV_QUEUED;
                  end
               end else begin
                  tag_in   = req_chan.job_tag;
                  steps_in = len_ff;
                  found_in = 1'b0;
                  state_in = ST_FIND;
               end
            end
         end

         // Rotate the table once; the first running job with the tag drops out.
         ST_FIND: begin
            if (steps_ff == '0) begin
               pend_tag_in  = tag_ff;
               pend_kind_in = found_ff ? cffd_pkg::EV_RELEASED : cffd_pkg::EV_UNKNOWN;
               results_in   = RW'(1);
               steps_in     = len_ff;
               state_in     = ST_SCAN;
            end else begin
               chain_ctl.shift = 1'b1;
               steps_in        = steps_ff - CNT_W'(1);
               if (head_match) begin
                  found_in = 1'b1;
                  len_in   = len_m1;
                  free_in  = (release_sum > {1'b0, total_ff}) ? total_ff : release_sum[CW-1:0];
                  busy_in  = busy_ff - BUSY_W'(head_entry.cores);
               end else begin
                  chain_ctl.load = 1'b1;
               end
            end
         end

         // Rotate the table once, starting every waiting job that fits until the result cap is met.
         ST_SCAN: begin
            if (steps_ff == '0) begin
               state_in = ST_DONE;
            end else if (!head_fit || slot_free) begin
               chain_ctl.shift = 1'b1;
               chain_ctl.load  = 1'b1;
               steps_in        = steps_ff - CNT_W'(1);
               if (head_fit) begin
                  wr_entry.running = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_tag_in   = pend_tag_ff;
                  rsp_kind_in  = pend_kind_ff;
                  rsp_last_in  = 1'b0;
                  pend_tag_in  = head_entry.tag;
                  pend_kind_in = cffd_pkg::EV_DISPATCHED;
                  results_in   = results_ff + RW'(1);
                  free_in      = free_ff - head_entry.cores;
                  busy_in      = busy_ff + BUSY_W'(head_entry.cores);
               end
            end
         end

         // Hand over the held result, now known to be the final one.
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_tag_in   = pend_tag_ff;
               rsp_kind_in  = pend_kind_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Configuration writes are to arrive only while the block is idle; the block does not enforce this.
      if (cfg_wr.write) begin
         total_in = cfg_wr.total;
         free_in  = free_cfg;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         steps_ff     <= '0;
         free_ff      <= CW'(1);
         total_ff     <= CW'(1);
         busy_ff      <= '0;
         found_ff     <= 1'b0;
         results_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         steps_ff     <= steps_in;
         free_ff      <= free_in;
         total_ff     <= total_in;
         busy_ff      <= busy_in;
         found_ff     <= found_in;
         results_ff   <= results_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      tag_ff       <= tag_in;
      pend_tag_ff  <= pend_tag_in;
      pend_kind_ff <= pend_kind_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.job_tag_res = rsp_tag_ff;
   assign rsp_chan.event_kind  = rsp_kind_ff;
   assign rsp_chan.last        = rsp_last_ff;
   assign total_cores          = total_ff;

endmodule

/* rtl/core/core_fit_fcfs_dispatcher_core.sv */
// ----------------------------------------------------------------------------
// First-fit FCFS core dispatcher
// Queues multi-core jobs in arrival order and starts each one that fits the
// free cores, reporting every queue, dispatch and release event.
// ----------------------------------------------------------------------------
// The job table is a row of TABLE_DEPTH cells that rotates towards cell 0;
// the sequencer looks at cell 0 once per cycle, holding while a job that
// fits waits for room in the result register, and writes the entry back at
// the tail. A submit, stored or refused, makes a dispatch pass over the
// table; a finish makes a search pass first. The result side can hold back
// a dispatch or the final result. Each request yields one event result
// followed by one result per started job, 16 at most, and the final one
// carries last. The request side is closed until that final result has
// entered the output register. Writing total_cores sets the pool size and
// recomputes the free cores from the running jobs; it starts no job.
`include "core_fit_fcfs_dispatcher_core_defines.svh"

module core_fit_fcfs_dispatcher_core #(
   parameter int unsigned TABLE_DEPTH = cffd_pkg::TABLE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   cffd_req_if.sink                           req_chan,
   cffd_rsp_if.source                         rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cffd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [cffd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [cffd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

   cffd_pkg::cfg_write_type              cfg_wr;
   logic [cffd_pkg::CORES_W-1:0]         total_cores;
   cffd_pkg::chain_ctl_type              chain_ctl;
   logic [IDX_W-1:0]                     wr_pos;
   cffd_pkg::entry_type                  wr_entry;
   cffd_pkg::entry_type                  cell_entry [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]               cell_load;
   logic                                 csr_hit;

   // Register decode: the total core count is the only register.
   assign csr_hit      = (csr_paddr[cffd_pkg::CSR_ADDR_W-1:2] == cffd_pkg::REG_TOTAL_CORES);
   assign cfg_wr.write = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign cfg_wr.total = csr_pwdata[cffd_pkg::CORES_W-1:0];
   assign csr_pready   = 1'b1;
   assign csr_prdata   = csr_hit
                         ? {{(cffd_pkg::CSR_DATA_W - cffd_pkg::CORES_W){1'b0}}, total_cores}
                         : '0;

   // Sequencer.
   cffd_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .cfg_wr      (cfg_wr),
      .total_cores (total_cores),
      .head_entry  (cell_entry[0]),
      .chain_ctl   (chain_ctl),
      .wr_pos      (wr_pos),
      .wr_entry    (wr_entry)
   );

   // Row of table cells; each but the top one takes its upper neighbour on a shift.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      cffd_pkg::cell_ctl_type ctl;
      cffd_pkg::entry_type    nbr;

      assign ctl.shift    = chain_ctl.shift;
      assign ctl.load     = chain_ctl.load && (wr_pos == IDX_W'(i));
      assign cell_load[i] = ctl.load;

      if (i == TABLE_DEPTH - 1) begin : g_top
         assign nbr = cell_entry[i];
      end else begin : g_mid
         assign nbr = cell_entry[i + 1];
      end

      cffd_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .nbr_entry (nbr),
         .wr_entry  (wr_entry),
         .entry     (cell_entry[i])
      );
   end

   // At most one cell is refilled in any cycle.
   `CFFD_ASSERT_SAME(a_single_load, clock, reset, 1'b1, $onehot0(cell_load))
   // Accepting a request closes the request side for the next cycle.
   `CFFD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   // The table does not shift while the block waits for a request.
   `CFFD_ASSERT_SAME(a_idle_no_shift, clock, reset, req_chan.ready, !chain_ctl.shift)

endmodule

/* verif/dispatch_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispatcher result checker
// Watches the request, result and register ports of the core dispatcher. It
// keeps its own job table and core pool, works out the results that each
// accepted request must give, and compares every result with the oldest one.
// ----------------------------------------------------------------------------
module dispatch_checker #(
   parameter int unsigned DEPTH = cffd_pkg::TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   cffd_req_if                                 req_mon,
   cffd_rsp_if                                 rsp_mon,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic                                csr_pready,
   input  logic [cffd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cffd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output int unsigned                         mismatches,
   output int unsigned                         awaiting
);

   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic [cffd_pkg::TAG_W-1:0]  tag;
      logic [cffd_pkg::KIND_W-1:0] kind;
      logic                        last;
   } job_event_type;

   // Job table in arrival order, entries 0 .. job_count-1.
   logic [cffd_pkg::TAG_W-1:0]   job_tag_tab  [DEPTH];
   logic [cffd_pkg::CORES_W-1:0] job_need_tab [DEPTH];
   logic                         job_run_tab  [DEPTH];
   int unsigned                  job_count;
   int unsigned                  pool_total;
   int unsigned                  pool_free;

   // Results of the request being worked out, and those still owed.
   job_event_type      step_events [$];
   job_event_type      owed_events [$];

   function automatic void note_event(input logic [cffd_pkg::TAG_W-1:0] tag,
                                      input logic [cffd_pkg::KIND_W-1:0] kind);
      job_event_type ev;
      ev.tag  = tag;
      ev.kind = kind;
      ev.last = 1'b0;
      step_events.push_back(ev);
   endfunction

   // Closes the gap left by a job that has gone.
   function automatic void drop_job(input int unsigned slot);
      int unsigned j;
      for (j = slot; j + 1 < job_count; j++) begin
         job_tag_tab[j]  = job_tag_tab[j+1];
         job_need_tab[j] = job_need_tab[j+1];
         job_run_tab[j]  = job_run_tab[j+1];
      end
      job_count--;
   endfunction

   // Resizes the pool; the free cores follow from the jobs still running.
   function automatic void resize_pool(input logic [cffd_pkg::CORES_W-1:0] total);
      int unsigned busy;
      int unsigned j;
      busy = 0;
      for (j = 0; j < job_count; j++) begin
         if (job_run_tab[j]) busy += job_need_tab[j];
      end
      pool_total = total;
      pool_free  = (busy >= pool_total) ? 0 : pool_total - busy;
   endfunction

   // Applies one request to the table and queues the results it must give.
   function automatic void dispatch_request(input logic op,
                                            input logic [cffd_pkg::TAG_W-1:0] tag,
                                            input logic [cffd_pkg::CORES_W-1:0] need);
      int unsigned   idx;
      int unsigned   sum;
      int unsigned   n;
      logic          found;
      job_event_type ev;
      step_events.delete();
      if (op == cffd_pkg::OP_SUBMIT) begin
         if (need > pool_total) begin
            note_event(tag, cffd_pkg::EV_TOO_MANY);
         end else if (job_count >= DEPTH) begin
            note_event(tag, cffd_pkg::EV_TABLE_FULL);
         end else begin
            job_tag_tab[job_count]  = tag;
            job_need_tab[job_count] = need;
            job_run_tab[job_count]  = 1'b0;
            job_count++;
            note_event(tag, cffd_pkg::EV_QUEUED);
         end
      end else begin
         // Only a running job can be finished; the first match in order goes.
         found = 1'b0;
         for (idx = 0; idx < job_count && !found; idx++) begin
            if (job_run_tab[idx] && job_tag_tab[idx] == tag) begin
               sum       = pool_free + job_need_tab[idx];
               pool_free = (sum > pool_total) ? pool_total : sum;
               drop_job(idx);
               found = 1'b1;
            end
         end
         note_event(tag, found ? cffd_pkg::EV_RELEASED : cffd_pkg::EV_UNKNOWN);
      end
      // First-fit pass over the waiting jobs, stopping at the result cap.
      for (idx = 0; idx < job_count; idx++) begin
         if (step_events.size() >= cffd_pkg::MAX_RESULTS) break;
         if (!job_run_tab[idx] && job_need_tab[idx] <= pool_free) begin
            job_run_tab[idx] = 1'b1;
            pool_free -= job_need_tab[idx];
            note_event(job_tag_tab[idx], cffd_pkg::EV_DISPATCHED);
         end
      end
      n = step_events.size();
      for (idx = 0; idx < n; idx++) begin
         ev      = step_events[idx];
         ev.last = (idx == n - 1);
         owed_events.push_back(ev);
      end
   endfunction

   // Follow the three ports at every rising edge.
   always @(posedge clock) begin
      job_event_type got;
      job_event_type want;
      if (reset) begin
         job_count  = 0;
         pool_total = 1;
         pool_free  = 1;
         owed_events.delete();
         mismatches = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[cffd_pkg::CSR_ADDR_W-1:2] == cffd_pkg::REG_TOTAL_CORES) begin
            resize_pool(csr_pwdata[cffd_pkg::CORES_W-1:0]);
         end
         if (req_mon.valid && req_mon.ready) begin
            dispatch_request(req_mon.operation, req_mon.job_tag, req_mon.cores_needed);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.tag  = rsp_mon.job_tag_res;
            got.kind = rsp_mon.event_kind;
            got.last = rsp_mon.last;
            if (owed_events.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected result job %0d kind %0d last %0b",
                           $realtime, got.tag, got.kind, got.last);
            end else begin
               want = owed_events.pop_front();
               if (got.tag !== want.tag || got.kind !== want.kind ||
                   got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"%0t: result mismatch, expected job %0d kind %0d last %0b, ",
                               "got job %0d kind %0d last %0b"}, $realtime,
                              want.tag, want.kind, want.last,
                              got.tag, got.kind, got.last);
               end
            end
         end
      end
      awaiting = owed_events.size();
   end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Core dispatcher testbench
// Drives submit and finish requests and register writes into the dispatcher,
// first a directed set of corner cases, then random phases with varied idling
// and pool sizes, and passes only with no mismatch and no result owed.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned TW            = cffd_pkg::TAG_W;
   localparam int unsigned CW            = cffd_pkg::CORES_W;
   localparam int unsigned AW            = cffd_pkg::CSR_ADDR_W;
   localparam int unsigned DW            = cffd_pkg::CSR_DATA_W;
   localparam int unsigned RUN_LIMIT     = 500000;
   localparam int unsigned SETTLE_CYCLES = 2 * cffd_pkg::TABLE_DEPTH + 8;
   localparam int unsigned PHASE_ITEMS   = 72;
   localparam int unsigned LONG_HOLD     = 400;
   localparam logic [AW-1:0] TOTAL_CORES_ADDR = {cffd_pkg::REG_TOTAL_CORES, 2'b00};
   localparam logic [AW-1:0] UNMAPPED_ADDR    = TOTAL_CORES_ADDR + 3'd4;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [AW-1:0]         csr_paddr;
   logic [DW-1:0]         csr_pwdata;
   logic [DW-1:0]         csr_prdata;
   logic                  csr_pready;

   int unsigned           mismatches;
   int unsigned           awaiting;
   int unsigned           cycle_count = 0;
   int unsigned           send_idle_pct = 0;
   int unsigned           stall_pct = 0;
   int unsigned           hold_request = 0;

   // Tags seen dispatched, from which finish requests are drawn.
   logic [TW-1:0]         running_tags [$];
   logic [TW-1:0]         next_tag = 8'h10;

   cffd_req_if req_chan ();
   cffd_rsp_if rsp_chan ();

   core_fit_fcfs_dispatcher_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dispatch_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .mismatches  (mismatches),
      .awaiting    (awaiting)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Collect dispatched tags so that most finish requests hit a running job.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready &&
          rsp_chan.event_kind == cffd_pkg::EV_DISPATCHED) begin
         running_tags.push_back(rsp_chan.job_tag_res);
      end
   end

   // Result side: random stalls, and long hold-offs counted here.
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Offers one request, after random idle cycles, and waits for acceptance.
   task automatic offer(input logic op, input logic [TW-1:0] tag,
                        input logic [CW-1:0] need);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= op;
      req_chan.job_tag      <= tag;
      req_chan.cores_needed <= need;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Stops sending and waits until every owed result has come back.
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task automatic write_reg(input logic [AW-1:0] addr,
                            input logic [CW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= ($urandom() << CW) | value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Mostly well-formed traffic: finishes of running jobs and fitting submits,
   // with some stray finishes and oversized or empty core requests.
   task automatic random_phase(input int unsigned count, input int unsigned pool);
      int unsigned      k;
      int unsigned      roll;
      int unsigned      pick;
      logic [TW-1:0]    tag;
      logic [CW-1:0]    need;
      for (k = 0; k < count; k++) begin
         roll = $urandom_range(99);
         if (roll < 50 && running_tags.size() != 0) begin
            pick = $urandom_range(running_tags.size() - 1);
            tag  = running_tags[pick];
            running_tags.delete(pick);
            offer(cffd_pkg::OP_FINISH, tag, CW'($urandom()));
         end else if (roll < 58) begin
            offer(cffd_pkg::OP_FINISH, TW'($urandom()), CW'($urandom()));
         end else begin
            if ($urandom_range(9) == 0) begin
               tag = TW'($urandom());
            end else begin
               tag      = next_tag;
               next_tag = next_tag + 1'b1;
            end
            pick = $urandom_range(19);
            if (pick == 0)
               need = '0;
            else if (pick < 3)
               need = CW'($urandom_range(cffd_pkg::MAX_CORES));
            else if (pick < 12)
               need = CW'($urandom_range(pool / 4 + 1, 1));
            else
               need = CW'($urandom_range(pool, 1));
            offer(cffd_pkg::OP_SUBMIT, tag, need);
         end
      end
   endtask

   initial begin
      int unsigned k;
      req_chan.valid        = 1'b0;
      req_chan.operation    = cffd_pkg::OP_SUBMIT;
      req_chan.job_tag      = '0;
      req_chan.cores_needed = '0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // One job takes the whole pool of 8, fifteen more wait behind it.
      write_reg(TOTAL_CORES_ADDR, 7'd8);
      offer(cffd_pkg::OP_SUBMIT, 8'h00, 7'd8);
      for (k = 1; k <= 15; k++) offer(cffd_pkg::OP_SUBMIT, TW'(k), 7'd8);
      // Table full, too many cores, and a finish for a job only waiting.
      offer(cffd_pkg::OP_SUBMIT, 8'hFF, 7'd8);
      offer(cffd_pkg::OP_SUBMIT, 8'h80, 7'h7F);
      offer(cffd_pkg::OP_FINISH, 8'h01, 7'd0);

      // Shrink the pool below the running job: its release saturates.
      settle();
      write_reg(TOTAL_CORES_ADDR, 7'd1);
      offer(cffd_pkg::OP_FINISH, 8'h00, 7'h7F);

      // Grow the pool without a pass, then a submit starts more jobs than
      // one request may report; the job left over starts on the next request.
      settle();
      write_reg(TOTAL_CORES_ADDR, 7'h7F);
      offer(cffd_pkg::OP_SUBMIT, 8'hAA, 7'd1);
      offer(cffd_pkg::OP_FINISH, 8'h55, 7'd0);
      offer(cffd_pkg::OP_SUBMIT, 8'h7E, 7'd0);

      // An empty pool: a submit that needs no cores meets the full table.
      settle();
      write_reg(TOTAL_CORES_ADDR, 7'd0);
      offer(cffd_pkg::OP_SUBMIT, 8'h3C, 7'd0);
      settle();
      write_reg(UNMAPPED_ADDR, 7'h7F);
      offer(cffd_pkg::OP_SUBMIT, 8'hC3, 7'd1);

      // Smallest pool, back to back traffic.
      settle();
      write_reg(TOTAL_CORES_ADDR, 7'd1);
      random_phase(PHASE_ITEMS, 1);

      // Sparse requests.
      settle();
      write_reg(TOTAL_CORES_ADDR, 7'd64);
      send_idle_pct = 78;
      random_phase(PHASE_ITEMS, 64);

      // Slow result side with a random pool size.
      settle();
      k = $urandom_range(126, 2);
      write_reg(TOTAL_CORES_ADDR, CW'(k));
      send_idle_pct = 0;
      stall_pct     = 78;
      random_phase(PHASE_ITEMS, k);

      // Largest pool, light idling on both sides.
      settle();
      write_reg(TOTAL_CORES_ADDR, 7'h7F);
      send_idle_pct = 24;
      stall_pct     = 24;
      random_phase(PHASE_ITEMS, 127);

      // Long hold-off on the result side while requests keep coming.
      settle();
      write_reg(TOTAL_CORES_ADDR, 7'd64);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_request  = LONG_HOLD;
      random_phase(PHASE_ITEMS, 64);

      settle();
      if (mismatches == 0 && awaiting == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
